// ===== rtl/core/ray_obb_slab_test_unit_macros.svh =====
// Assertion helpers for the ray/box slab test unit.
`ifndef RAY_OBB_SLAB_TEST_UNIT_MACROS_SVH
`define RAY_OBB_SLAB_TEST_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ROBB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("robb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ROBB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("robb assertion failed");

`endif

// ===== rtl/core/robb_pkg.sv =====
// ----------------------------------------------------------------------------
// robb_pkg
// Shared constants for the ray/box slab test unit: register indexes, axis
// index codes, reset values and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package robb_pkg;

  // Configuration register indexes
  localparam logic [2:0] RegOriginX = 3'd0;
  localparam logic [2:0] RegOriginY = 3'd1;
  localparam logic [2:0] RegOriginZ = 3'd2;
  localparam logic [2:0] RegDirX    = 3'd3;
  localparam logic [2:0] RegDirY    = 3'd4;
  localparam logic [2:0] RegDirZ    = 3'd5;
  localparam logic [2:0] RegMaxDist = 3'd6;

  // Axis index codes
  localparam logic [1:0] AxisFirst = 2'd0;
  localparam logic [1:0] AxisLast  = 2'd2;
  localparam logic [1:0] AxisNone  = 2'd3;

  // Reset values
  localparam logic signed [17:0] DirZReset    = 18'sd65536;
  localparam logic        [30:0] MaxDistReset = 31'h7FFF_FFFF;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 3;

endpackage

// ===== rtl/core/robb_if.sv =====
// ----------------------------------------------------------------------------
// robb_in_if / robb_out_if
// Valid/ready channels carrying one box axis in and one hit result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface robb_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  axis_index;
  logic signed [31:0] axis_x;
  logic signed [31:0] axis_y;
  logic signed [31:0] axis_z;
  logic signed [31:0] slab_min;
  logic signed [31:0] slab_max;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, axis_index, axis_x, axis_y, axis_z, slab_min, slab_max,
                  pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, axis_index, axis_x, axis_y, axis_z, slab_min, slab_max,
                  pos_x, pos_y, pos_z, output ready);
endinterface

interface robb_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink   (input valid, hit, hit_distance, output ready);
endinterface

// ===== rtl/core/robb_div.sv =====
// ----------------------------------------------------------------------------
// robb_div
// Bit-serial restoring divider: (num << FRAC_BITS) / den, truncated toward
// zero and saturated to signed 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module robb_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  localparam int unsigned QW = 33 + FRAC_BITS;
  localparam int unsigned CW = $clog2(QW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [QW-1:0] dvd_q, dvd_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [31:0]   rem_q, rem_d;
  logic [31:0]   den_q, den_d;
  logic          neg_q, neg_d;

  logic [33:0] num_neg;
  logic [32:0] num_mag;
  logic [32:0] den_neg;
  logic [32:0] trial;
  logic [32:0] diff;

  // Magnitudes at start
  assign num_neg = -{num_i[32], num_i};
  assign num_mag = num_i[32] ? num_neg[32:0] : num_i;
  assign den_neg = -{den_i[31], den_i};

  // One restoring step
  assign trial = {rem_q, dvd_q[QW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(QW);
      dvd_d  = {num_mag, {FRAC_BITS{1'b0}}};
      quo_d  = '0;
      rem_d  = '0;
      den_d  = den_i[31] ? den_neg[31:0] : den_i;
      neg_d  = num_i[32] ^ den_i[31];
    end else if (busy_q) begin
      dvd_d = {dvd_q[QW-2:0], 1'b0};
      if (!diff[32]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // Sign and saturate
  logic [QW-1:0] quo_neg;
  assign quo_neg = -quo_q;

  always_comb begin
    if (neg_q) begin
      if (quo_q > QW'(33'h0_8000_0000)) quo_o = 32'sh8000_0000;
      else                              quo_o = quo_neg[31:0];
    end else begin
      if (quo_q > QW'(32'h7FFF_FFFF)) quo_o = 32'sh7FFF_FFFF;
      else                            quo_o = quo_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/core/ray_obb_slab_test_unit.sv =====
// ----------------------------------------------------------------------------
// ray_obb_slab_test_unit
// Ray against oriented box, slab method, signed fixed point. One input
// transaction per box axis; the last axis yields one hit transaction.
// ----------------------------------------------------------------------------
//  channel   dir   contents
//  in_i      in    axis_index, axis vector, slab edges, box position
//  out_o     out   hit, hit_distance (after axis 2 only)
//  cfg       in    cfg_we_i / cfg_idx_i / cfg_data_i, write only
//
// An axis passes through acceptance, bit-serial multiply (six lanes), sum,
// decision, a wait on the two serial dividers (33+FRAC_BITS quotient bits
// each), update and result; a parallel or already-missed axis skips the dividers.
// One axis is in flight at a time; in_i.ready is high only when idle.
// The result register holds the hit until out_o.ready; a later axis 2 waits.
// Reset is asynchronous and sets control and configuration registers to their reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ray_obb_slab_test_unit_macros.svh"

module ray_obb_slab_test_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [robb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [robb_pkg::CfgDataW-1:0]   cfg_data_i,
  robb_in_if.sink                         in_i,
  robb_out_if.source                      out_o
);

  localparam logic signed [31:0] Eps = 32'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUM, S_DEC, S_DIV, S_UPD, S_OUT
  } state_e;

  // Configuration registers
  logic signed [31:0] origin_q [3];
  logic signed [17:0] dir_q    [3];
  logic        [30:0] maxd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= '0;
      origin_q[1] <= '0;
      origin_q[2] <= '0;
      dir_q[0]    <= '0;
      dir_q[1]    <= '0;
      dir_q[2]    <= robb_pkg::DirZReset;
      maxd_q      <= robb_pkg::MaxDistReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        robb_pkg::RegOriginX: origin_q[0] <= cfg_data_i;
        robb_pkg::RegOriginY: origin_q[1] <= cfg_data_i;
        robb_pkg::RegOriginZ: origin_q[2] <= cfg_data_i;
        robb_pkg::RegDirX:    dir_q[0]    <= cfg_data_i[17:0];
        robb_pkg::RegDirY:    dir_q[1]    <= cfg_data_i[17:0];
        robb_pkg::RegDirZ:    dir_q[2]    <= cfg_data_i[17:0];
        robb_pkg::RegMaxDist: maxd_q      <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Control and datapath registers
  state_e             state_q, state_d;
  logic [4:0]         mcnt_q, mcnt_d;
  logic [1:0]         idx_q, idx_d;
  logic signed [32:0] hi_q [6];
  logic signed [32:0] hi_d [6];
  logic [31:0]        lo_q [6];
  logic [31:0]        lo_d [6];
  logic signed [31:0] mc_q [6];
  logic signed [31:0] mc_d [6];
  logic signed [31:0] smin_q, smin_d, smax_q, smax_d;
  logic signed [31:0] e_q, e_d, f_q, f_d;
  logic signed [31:0] near_q, near_d, far_q, far_d;
  logic               missed_q, missed_d;
  logic               ovalid_q, ovalid_d;
  logic               hit_q, hit_d;
  logic [30:0]        dist_q, dist_d;

  // Divider lanes
  logic               div_start;
  logic signed [32:0] num_a, num_b;
  logic               done_a, done_b;
  logic signed [31:0] quo_a, quo_b;

  robb_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_a), .den_i(f_q),
    .done_o(done_a), .quo_o(quo_a)
  );

  robb_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_b), .den_i(f_q),
    .done_o(done_b), .quo_o(quo_b)
  );

  assign num_a = {e_q[31], e_q} + {smin_q[31], smin_q};
  assign num_b = {e_q[31], e_q} + {smax_q[31], smax_q};

  // Saturate a wide signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
    else                            r = v[31:0];
    return r;
  endfunction

  // Position minus origin, saturated
  logic signed [31:0] pos_in [3];
  logic signed [31:0] delta  [3];
  logic signed [32:0] dsub   [3];

  assign pos_in[0] = in_i.pos_x;
  assign pos_in[1] = in_i.pos_y;
  assign pos_in[2] = in_i.pos_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsub[k] = {pos_in[k][31], pos_in[k]} - {origin_q[k][31], origin_q[k]};
      if (dsub[k][32] != dsub[k][31]) delta[k] = dsub[k][32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else                            delta[k] = dsub[k][31:0];
    end
  end

  // Bit-serial multiply step, products and sums
  logic signed [32:0] madd   [6];
  logic signed [33:0] msum   [6];
  logic signed [63:0] prod   [6];
  logic signed [63:0] prod_s [6];
  logic signed [65:0] e_sum, f_sum;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      madd[k]   = (mcnt_q == 5'd31) ? -{mc_q[k][31], mc_q[k]} : {mc_q[k][31], mc_q[k]};
      msum[k]   = lo_q[k][0] ? ({hi_q[k][32], hi_q[k]} + {madd[k][32], madd[k]})
                             : {hi_q[k][32], hi_q[k]};
      prod[k]   = {hi_q[k][31:0], lo_q[k]};
      prod_s[k] = prod[k] >>> FRAC_BITS;
    end
    e_sum = 66'(prod_s[0]) + 66'(prod_s[1]) + 66'(prod_s[2]);
    f_sum = 66'(prod_s[3]) + 66'(prod_s[4]) + 66'(prod_s[5]);
  end

  // Bound update
  logic signed [31:0] t_lo, t_hi, far_n, near_n;
  assign t_lo   = (quo_a > quo_b) ? quo_b : quo_a;
  assign t_hi   = (quo_a > quo_b) ? quo_a : quo_b;
  assign far_n  = (t_hi < far_q) ? t_hi : far_q;
  assign near_n = (t_lo > near_q) ? t_lo : near_q;

  assign in_i.ready = (state_q == S_IDLE);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    mcnt_d    = mcnt_q;
    idx_d     = idx_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    mc_d      = mc_q;
    smin_d    = smin_q;
    smax_d    = smax_q;
    e_d       = e_q;
    f_d       = f_q;
    near_d    = near_q;
    far_d     = far_q;
    missed_d  = missed_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    hit_d     = hit_q;
    dist_d    = dist_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_i.axis_index != robb_pkg::AxisNone) begin
          idx_d  = in_i.axis_index;
          smin_d = in_i.slab_min;
          smax_d = in_i.slab_max;
          lo_d[0] = in_i.axis_x; lo_d[1] = in_i.axis_y; lo_d[2] = in_i.axis_z;
          lo_d[3] = in_i.axis_x; lo_d[4] = in_i.axis_y; lo_d[5] = in_i.axis_z;
          for (int k = 0; k < 3; k++) begin
            mc_d[k]     = delta[k];
            mc_d[k + 3] = 32'(dir_q[k]);
          end
          for (int k = 0; k < 6; k++) hi_d[k] = '0;
          mcnt_d = '0;
          if (in_i.axis_index == robb_pkg::AxisFirst) begin
            near_d   = '0;
            far_d    = {1'b0, maxd_q};
            missed_d = 1'b0;
          end
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        for (int k = 0; k < 6; k++) begin
          hi_d[k] = msum[k][33:1];
          lo_d[k] = {msum[k][0], lo_q[k][31:1]};
        end
        mcnt_d = mcnt_q + 5'd1;
        if (mcnt_q == 5'd31) state_d = S_SUM;
      end
      S_SUM: begin
        e_d     = sat32(e_sum);
        f_d     = sat32(f_sum);
        state_d = S_DEC;
      end
      S_DEC: begin
        if (missed_q) begin
          state_d = S_OUT;
        end else if (f_q > Eps || f_q < -Eps) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          if (smin_q > e_q || smax_q < e_q) missed_d = 1'b1;
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (done_a) state_d = S_UPD;
      end
      S_UPD: begin
        far_d  = far_n;
        near_d = near_n;
        if (far_n < near_n) missed_d = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (idx_q != robb_pkg::AxisLast) begin
          state_d = S_IDLE;
        end else if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          hit_d    = !missed_q;
          dist_d   = missed_q ? '0 : near_q[30:0];
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mcnt_q   <= '0;
      idx_q    <= '0;
      near_q   <= '0;
      far_q    <= {1'b0, robb_pkg::MaxDistReset};
      missed_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mcnt_q   <= mcnt_d;
      idx_q    <= idx_d;
      near_q   <= near_d;
      far_q    <= far_d;
      missed_q <= missed_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    mc_q   <= mc_d;
    smin_q <= smin_d;
    smax_q <= smax_d;
    e_q    <= e_d;
    f_q    <= f_d;
    hit_q  <= hit_d;
    dist_q <= dist_d;
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.hit          = hit_q;
  assign out_o.hit_distance = dist_q;

  // Checks
  `ROBB_ASSERT_NOW(a_bounds_ordered, clk_i, rst_ni, !missed_q, far_q >= near_q)
  `ROBB_ASSERT_NOW(a_div_lanes_agree, clk_i, rst_ni, done_a, done_b)
  `ROBB_ASSERT_NEXT(a_result_matches, clk_i, rst_ni,
                    state_q == S_OUT && state_d == S_IDLE && idx_q == robb_pkg::AxisLast,
                    ovalid_q && hit_q == !missed_q)
  `ROBB_ASSERT_NOW(a_div_only_in_div, clk_i, rst_ni, done_a, state_q == S_DIV)

endmodule

// ===== dv/ray_obb_slab_checker.sv =====
// ----------------------------------------------------------------------------
// Ray/box slab test checker
// Passive monitor for the slab test unit. It tracks register writes, predicts
// the hit result of every box from the accepted axis transactions, and checks
// each result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_obb_slab_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [robb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [robb_pkg::CfgDataW-1:0] cfg_data_i,
  robb_in_if                            in_mon,
  robb_out_if                           out_mon,
  output int unsigned                   fail_count,
  output int unsigned                   pending_count
);

  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;
  localparam longint OneQ   = 64'sd1 << FRAC_BITS;
  // parallel threshold, 0.0001 in fixed point
  localparam longint EpsQ   = (OneQ + 5000) / 10000;

  typedef struct packed {
    logic        hit;
    logic [30:0] hit_distance;
  } hit_result_t;

  hit_result_t hit_queue[$];

  // ray registers and per-box bounds
  longint ray_origin[3];
  longint ray_dir[3];
  longint max_dist;
  longint near_b;
  longint far_b;
  bit     missed;

  function automatic longint sat32(longint v);
    if (v > S32Max) return S32Max;
    if (v < S32Min) return S32Min;
    return v;
  endfunction

  function automatic longint floor_q(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint slab_t(longint num, longint den);
    return sat32((num * OneQ) / den);
  endfunction

  task automatic predict_axis(logic [1:0] idx, longint ax, longint ay, longint az,
                              longint smin, longint smax,
                              longint px, longint py, longint pz);
    longint dx, dy, dz, e, f, t1, t2, w;
    hit_result_t res;
    if (idx == robb_pkg::AxisNone) return;
    if (idx == robb_pkg::AxisFirst) begin
      near_b = 0;
      far_b  = max_dist;
      missed = 1'b0;
    end
    dx = sat32(px - ray_origin[0]);
    dy = sat32(py - ray_origin[1]);
    dz = sat32(pz - ray_origin[2]);
    e = sat32(floor_q(ax * dx) + floor_q(ay * dy) + floor_q(az * dz));
    f = sat32(floor_q(ray_dir[0] * ax) + floor_q(ray_dir[1] * ay) + floor_q(ray_dir[2] * az));
    if (!missed) begin
      if (f > EpsQ || f < -EpsQ) begin
        t1 = slab_t(e + smin, f);
        t2 = slab_t(e + smax, f);
        if (t1 > t2) begin
          w  = t1;
          t1 = t2;
          t2 = w;
        end
        if (t2 < far_b) far_b = t2;
        if (t1 > near_b) near_b = t1;
        if (far_b < near_b) missed = 1'b1;
      end else begin
        // near-parallel axis: origin must lie inside the slab
        if (smin > e || smax < e) missed = 1'b1;
      end
    end
    if (idx != robb_pkg::AxisLast) return;
    res.hit          = !missed;
    res.hit_distance = missed ? 31'd0 : near_b[30:0];
    hit_queue.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hit_result_t exp_res;
    if (!rst_ni) begin
      ray_origin = '{0, 0, 0};
      ray_dir    = '{0, 0, longint'(robb_pkg::DirZReset)};
      max_dist   = longint'(robb_pkg::MaxDistReset);
      near_b     = 0;
      far_b      = max_dist;
      missed     = 1'b0;
      fail_count = 0;
      hit_queue.delete();
      pending_count = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          robb_pkg::RegOriginX: ray_origin[0] = longint'($signed(cfg_data_i));
          robb_pkg::RegOriginY: ray_origin[1] = longint'($signed(cfg_data_i));
          robb_pkg::RegOriginZ: ray_origin[2] = longint'($signed(cfg_data_i));
          robb_pkg::RegDirX:    ray_dir[0] = longint'($signed(cfg_data_i[17:0]));
          robb_pkg::RegDirY:    ray_dir[1] = longint'($signed(cfg_data_i[17:0]));
          robb_pkg::RegDirZ:    ray_dir[2] = longint'($signed(cfg_data_i[17:0]));
          robb_pkg::RegMaxDist: max_dist = longint'({1'b0, cfg_data_i[30:0]});
          default: ;
        endcase
      end
      // axis transaction
      if (in_mon.valid && in_mon.ready) begin
        predict_axis(in_mon.axis_index, in_mon.axis_x, in_mon.axis_y, in_mon.axis_z,
                     in_mon.slab_min, in_mon.slab_max,
                     in_mon.pos_x, in_mon.pos_y, in_mon.pos_z);
      end
      // result transaction
      if (out_mon.valid && out_mon.ready) begin
        if (hit_queue.size() == 0) begin
          $error("unexpected result transaction: hit=%0b hit_distance=%0d",
                 out_mon.hit, out_mon.hit_distance);
          fail_count++;
        end else begin
          exp_res = hit_queue.pop_front();
          if (out_mon.hit !== exp_res.hit) begin
            $error("hit mismatch: expected %0b actual %0b", exp_res.hit, out_mon.hit);
            fail_count++;
          end
          if (out_mon.hit_distance !== exp_res.hit_distance) begin
            $error("hit_distance mismatch: expected %0d actual %0d",
                   exp_res.hit_distance, out_mon.hit_distance);
            fail_count++;
          end
        end
      end
      pending_count = hit_queue.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Ray/box slab test bench
// Drives box axis transactions through the slab test unit under several ray
// settings: a directed set of boxes and corner cases, then random boxes with
// some noise, with random idling on both channels. Checking is done by the
// checker instance; this top makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] AxisMid   = 2'd1;
  localparam int unsigned IdxW     = robb_pkg::CfgIdxW;
  localparam int         OneQ      = 65536;
  localparam int         NumPhases = 6;
  localparam int         PhaseItems = 60;
  localparam int         DrainCycles = 150;
  localparam int         CycleLimit = 800000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [robb_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [robb_pkg::CfgDataW-1:0] cfg_data_i;
  int unsigned         fail_count;
  int unsigned         pending_count;
  int unsigned         cycle_count = 0;
  bit                  in_burst;
  bit                  out_burst;

  robb_in_if  axis_ch();
  robb_out_if hit_ch();

  ray_obb_slab_test_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (axis_ch),
    .out_o      (hit_ch)
  );

  ray_obb_slab_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_mon        (axis_ch),
    .out_mon       (hit_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // gap length: mostly none or short, a few long
  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // random fixed-point value within +/- span units
  function automatic int rand_coord(int span);
    return int'($urandom_range(0, 2 * span * OneQ)) - span * OneQ;
  endfunction

  // result side back-pressure
  initial begin
    int stall;
    out_burst    = 1'b0;
    hit_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 49) == 0) out_burst = ~out_burst;
      stall = pick_gap(out_burst);
      if (stall > 0) begin
        hit_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      hit_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_axis(logic [1:0] idx, int ax, int ay, int az, int smin, int smax,
                           int px, int py, int pz);
    int gap;
    axis_ch.valid      <= 1'b1;
    axis_ch.axis_index <= idx;
    axis_ch.axis_x     <= ax;
    axis_ch.axis_y     <= ay;
    axis_ch.axis_z     <= az;
    axis_ch.slab_min   <= smin;
    axis_ch.slab_max   <= smax;
    axis_ch.pos_x      <= px;
    axis_ch.pos_y      <= py;
    axis_ch.pos_z      <= pz;
    // ready is sampled as the edge fires, before the design updates
    @(posedge clk_i iff axis_ch.ready);
    gap = pick_gap(in_burst);
    if (gap > 0) begin
      axis_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_ray(int ox, int oy, int oz, int dx, int dy, int dz, int maxd);
    int vals[7];
    vals = '{ox, oy, oz, dx, dy, dz, maxd};
    for (int i = 0; i < 7; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= IdxW'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // let all boxes finish before touching the ray registers
  task automatic drain();
    axis_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one box: three axes with a shared position, optionally broken up
  task automatic send_box(bit broken);
    int px, py, pz, ax, ay, az, smin, smax, w, k;
    logic [1:0] idx;
    px = rand_coord(40);
    py = rand_coord(40);
    pz = rand_coord(40);
    for (int a = 0; a < 3; a++) begin
      idx = (a == 0) ? robb_pkg::AxisFirst : (a == 1) ? AxisMid : robb_pkg::AxisLast;
      if (broken && $urandom_range(0, 2) == 0) continue;
      if ($urandom_range(0, 1) == 0) begin
        k  = (a + $urandom_range(0, 2)) % 3;
        w  = $urandom_range(0, 1) ? OneQ : -OneQ;
        ax = (k == 0) ? w : 0;
        ay = (k == 1) ? w : 0;
        az = (k == 2) ? w : 0;
      end else begin
        ax = rand_coord(1);
        ay = rand_coord(1);
        az = rand_coord(1);
      end
      smin = -int'($urandom_range(OneQ / 4, 8 * OneQ));
      smax = int'($urandom_range(OneQ / 4, 8 * OneQ));
      if ($urandom_range(0, 19) == 0) begin
        w    = smin;
        smin = smax;
        smax = w;
      end
      send_axis(idx, ax, ay, az, smin, smax, px, py, pz);
    end
  endtask

  initial begin
    int items;
    int r;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_burst   = 1'b0;
    axis_ch.valid      = 1'b0;
    axis_ch.axis_index = robb_pkg::AxisFirst;
    axis_ch.axis_x     = '0;
    axis_ch.axis_y     = '0;
    axis_ch.axis_z     = '0;
    axis_ch.slab_min   = '0;
    axis_ch.slab_max   = '0;
    axis_ch.pos_x      = '0;
    axis_ch.pos_y      = '0;
    axis_ch.pos_z      = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset ray: origin at zero looking along +z
    // box ahead of the ray: hit
    send_axis(robb_pkg::AxisFirst, OneQ, 0, 0, -OneQ, OneQ, 0, 0, 10 * OneQ);
    send_axis(AxisMid, 0, OneQ, 0, -OneQ, OneQ, 0, 0, 10 * OneQ);
    send_axis(robb_pkg::AxisLast, 0, 0, OneQ, -OneQ, OneQ, 0, 0, 10 * OneQ);
    // ray parallel to an axis and outside its slab: miss
    send_axis(robb_pkg::AxisFirst, OneQ, 0, 0, -OneQ, OneQ, 5 * OneQ, 0, 10 * OneQ);
    send_axis(AxisMid, 0, OneQ, 0, -OneQ, OneQ, 5 * OneQ, 0, 10 * OneQ);
    send_axis(robb_pkg::AxisLast, 0, 0, OneQ, -OneQ, OneQ, 5 * OneQ, 0, 10 * OneQ);
    // box behind the origin: miss
    send_axis(robb_pkg::AxisFirst, 0, 0, -OneQ, -OneQ, OneQ, 0, 0, -10 * OneQ);
    send_axis(AxisMid, OneQ, 0, 0, -OneQ, OneQ, 0, 0, -10 * OneQ);
    send_axis(robb_pkg::AxisLast, 0, OneQ, 0, -OneQ, OneQ, 0, 0, -10 * OneQ);
    // f just at and just above the parallel threshold
    send_axis(robb_pkg::AxisFirst, 0, 0, 7, -OneQ, OneQ, 0, 0, 3 * OneQ);
    send_axis(AxisMid, 0, 0, 8, -OneQ, OneQ, 0, 0, 3 * OneQ);
    send_axis(robb_pkg::AxisLast, 0, 0, -8, -OneQ, OneQ, 0, 0, 3 * OneQ);
    // field extremes, saturating every stage
    send_axis(robb_pkg::AxisFirst, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_axis(AxisMid, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_axis(robb_pkg::AxisLast, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    // unused axis code is dropped; middle and last axes without a first
    send_axis(robb_pkg::AxisNone, OneQ, 0, 0, OneQ, -OneQ, 0, 0, 0);
    send_axis(AxisMid, 0, 0, OneQ, -2 * OneQ, 2 * OneQ, 0, 0, OneQ);
    send_axis(robb_pkg::AxisLast, 0, 0, OneQ, -OneQ, OneQ, 0, 0, 4 * OneQ);
    drain();

    // random phases across ray settings
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: write_ray(0, 0, 0, 0, 0, 65536, 32'h7FFF_FFFF);
        1: write_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     -65536, -65536, -65536, 0);
        2: write_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     65536, 65536, 0, $urandom_range(0, 32'h7FFF_FFFF));
        default: write_ray(rand_coord(60), rand_coord(60), rand_coord(60),
                           rand_coord(1), rand_coord(1), rand_coord(1),
                           $urandom_range(OneQ, 200 * OneQ));
      endcase
      items = 0;
      while (items < PhaseItems) begin
        if ($urandom_range(0, 9) == 0) in_burst = ~in_burst;
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_box(1'b0);
          items += 3;
        end else if (r < 88) begin
          send_box(1'b1);
          items += 2;
        end else begin
          send_axis(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom);
          items += 1;
        end
      end
      send_box(1'b0);
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
